// ===== src/gffrc_pkg.sv =====
package gffrc_pkg;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'h1FF;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_READ  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    NB_DOWN  = 2'd0,
    NB_UP    = 2'd1,
    NB_RIGHT = 2'd2,
    NB_LEFT  = 2'd3
  } dir_t;

  typedef struct packed {
    logic open_we;
    logic open_wd;
    logic mark_we;
    logic mark_wd;
  } cell_cmd_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_cmd_t;

endpackage

// ===== src/gffrc_cell_store.sv =====
module gffrc_cell_store #(
  parameter int CELLS = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  gffrc_pkg::cell_cmd_t cmd,
  input  logic [AW-1:0]        waddr,
  input  logic [AW-1:0]        raddr,
  output logic                 open_q,
  output logic                 mark_q
);
  import gffrc_pkg::*;

  logic open_mem [CELLS];
  logic mark_mem [CELLS];

  always_ff @(posedge clk) begin
    if (cmd.open_we) begin
      open_mem[waddr] <= cmd.open_wd;
    end
    open_q <= open_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_we) begin
      mark_mem[waddr] <= cmd.mark_wd;
    end
    mark_q <= mark_mem[raddr];
  end

endmodule

// ===== src/gffrc_stack.sv =====
module gffrc_stack #(
  parameter int CELLS = 256,
  parameter int AW    = 8,
  parameter int SPW   = 9,
  parameter int PW    = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gffrc_pkg::stack_cmd_t cmd,
  input  logic [PW-1:0]         wdata,
  output logic [PW-1:0]         rdata,
  output logic                  empty
);
  import gffrc_pkg::*;

  logic [PW-1:0]  stack_mem [CELLS];
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_dec;

  assign sp_dec = sp - 1'b1;
  assign empty  = (sp == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.clear) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + 1'b1;
    end else if (cmd.pop) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[sp[AW-1:0]] <= wdata;
    end
    if (cmd.pop) begin
      rdata <= stack_mem[sp_dec[AW-1:0]];
    end
  end

endmodule

// ===== src/grid_flood_fill_region_counter.sv =====
// Four-connected flood fill over a GRID_ROWS x GRID_COLS grid held in on-chip
// memories. An item is taken when start is high and busy is low; its single
// result appears on region_count and mark while done is high for one cycle,
// and must be captured then. After reset the block clears every cell of its
// memories with busy high. A cell write answers in the cycle after
// acceptance; a cell read answers after passing through S_READ. A fill first
// clears all reach marks, then seeds the start cell and walks a stack of
// visited cells (it ends after the seed step when the start cell is on the
// border or outside the grid): each popped cell probes its four neighbors one
// after another through the single read port of the cell memories, overlapping
// the write-back of one neighbor with the read of the next.
module grid_flood_fill_region_counter #(
  parameter int GRID_ROWS = 16,
  parameter int GRID_COLS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [3:0]                    row,
  input  logic [3:0]                    col,
  input  logic                          open,
  output logic                          done,
  output logic [gffrc_pkg::COUNT_W-1:0] region_count,
  output logic                          mark
);
  import gffrc_pkg::*;

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int SPW   = $clog2(CELLS + 1);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int PW    = ROW_W + COL_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_CLEAR = 8'b0000_1000,
    S_SEED  = 8'b0001_0000,
    S_POP   = 8'b0010_0000,
    S_LOAD  = 8'b0100_0000,
    S_PROBE = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    cell_addr = AW'(AW'(r) * AW'(GRID_COLS) + AW'(c));
  endfunction

  function automatic logic [PW-1:0] nbr(input logic [ROW_W-1:0] r,
                                        input logic [COL_W-1:0] c,
                                        input dir_t d);
    logic [ROW_W-1:0] nr;
    logic [COL_W-1:0] nc;
    nr = r;
    nc = c;
    case (d)
      NB_DOWN:  nr = r + 1'b1;
      NB_UP:    nr = r - 1'b1;
      NB_RIGHT: nc = c + 1'b1;
      NB_LEFT:  nc = c - 1'b1;
      default: ;
    endcase
    nbr = {nr, nc};
  endfunction

  function automatic logic on_border(input logic [ROW_W-1:0] r,
                                     input logic [COL_W-1:0] c);
    on_border = (r == '0) || (c == '0) ||
                (r == ROW_W'(GRID_ROWS - 1)) || (c == COL_W'(GRID_COLS - 1));
  endfunction

  state_t state, state_next;
  logic [AW-1:0]      cnt;
  logic [ROW_W-1:0]   start_r, cur_r, nb_r, nx_r, in_r;
  logic [COL_W-1:0]   start_c, cur_c, nb_c, nx_c, in_c, ld_c;
  logic [ROW_W-1:0]   ld_r;
  logic               seed_ok;
  logic               rd_ok;
  dir_t               nb;
  dir_t               nb_inc;
  logic [COUNT_W-1:0] count;
  logic               done_next;

  logic               accept;
  logic               in_ok;
  logic [AW-1:0]      in_addr;
  logic               probe_visit;

  cell_cmd_t          ccmd;
  logic [AW-1:0]      waddr, raddr;
  logic               open_q, mark_q;

  stack_cmd_t         scmd;
  logic [PW-1:0]      stk_wdata, stk_q;
  logic               stk_empty;

  assign accept       = start && !busy;
  assign busy         = (state != S_IDLE);
  assign region_count = count;
  assign in_r         = ROW_W'(row);
  assign in_c         = COL_W'(col);
  assign in_ok        = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
  assign in_addr      = cell_addr(in_r, in_c);
  assign nb_inc       = dir_t'(nb + 2'd1);
  assign {nb_r, nb_c} = nbr(cur_r, cur_c, nb);
  assign {nx_r, nx_c} = nbr(cur_r, cur_c, nb_inc);
  assign {ld_r, ld_c} = stk_q;
  assign probe_visit  = open_q && !mark_q && !on_border(nb_r, nb_c);

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    ccmd       = '0;
    scmd       = '0;
    waddr      = in_addr;
    raddr      = in_addr;
    stk_wdata  = {start_r, start_c};
    case (state)
      S_INIT: begin
        ccmd.open_we = 1'b1;
        ccmd.mark_we = 1'b1;
        waddr        = cnt;
        if (cnt == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_WRITE: begin
              ccmd.open_we = in_ok;
              ccmd.open_wd = open;
              done_next    = 1'b1;
            end
            ACT_FILL: begin
              scmd.clear = 1'b1;
              state_next = S_CLEAR;
            end
            ACT_READ: state_next = S_READ;
            default: done_next = 1'b1;
          endcase
        end
      end
      S_READ: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      S_CLEAR: begin
        ccmd.mark_we = 1'b1;
        waddr        = cnt;
        if (cnt == LAST_ADDR) begin
          state_next = S_SEED;
        end
      end
      S_SEED: begin
        waddr = cell_addr(start_r, start_c);
        if (seed_ok) begin
          ccmd.mark_we = 1'b1;
          ccmd.mark_wd = 1'b1;
          scmd.push    = 1'b1;
          state_next   = S_POP;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_POP: begin
        if (stk_empty) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          scmd.pop   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        raddr      = cell_addr(ld_r + 1'b1, ld_c);
        state_next = S_PROBE;
      end
      S_PROBE: begin
        waddr     = cell_addr(nb_r, nb_c);
        raddr     = cell_addr(nx_r, nx_c);
        stk_wdata = {nb_r, nb_c};
        if (open_q && !mark_q) begin
          if (probe_visit) begin
            ccmd.mark_we = 1'b1;
            ccmd.mark_wd = 1'b1;
            scmd.push    = 1'b1;
          end
        end else begin
          ccmd.mark_we = 1'b1;
          ccmd.mark_wd = 1'b1;
        end
        if (nb == NB_LEFT) begin
          state_next = S_POP;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt   <= '0;
      count <= '0;
      done  <= 1'b0;
      mark  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      case (state)
        S_INIT, S_CLEAR: begin
          cnt <= (cnt == LAST_ADDR) ? '0 : cnt + 1'b1;
        end
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_FILL: begin
                count   <= '0;
                start_r <= in_r;
                start_c <= in_c;
                seed_ok <= in_ok && !on_border(in_r, in_c);
              end
              ACT_READ: rd_ok <= in_ok;
              default: mark <= 1'b0;
            endcase
          end
        end
        S_READ: begin
          mark <= mark_q && rd_ok;
        end
        S_SEED: begin
          if (seed_ok) begin
            count <= COUNT_W'(1);
          end else begin
            mark <= 1'b0;
          end
        end
        S_POP: begin
          if (stk_empty) begin
            mark <= 1'b0;
          end
        end
        S_LOAD: begin
          cur_r <= ld_r;
          cur_c <= ld_c;
          nb    <= NB_DOWN;
        end
        S_PROBE: begin
          nb <= nb_inc;
          if (probe_visit && count != COUNT_MAX) begin
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  gffrc_cell_store #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_cells (
    .clk    (clk),
    .cmd    (ccmd),
    .waddr  (waddr),
    .raddr  (raddr),
    .open_q (open_q),
    .mark_q (mark_q)
  );

  gffrc_stack #(
    .CELLS (CELLS),
    .AW    (AW),
    .SPW   (SPW),
    .PW    (PW)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (scmd),
    .wdata (stk_wdata),
    .rdata (stk_q),
    .empty (stk_empty)
  );

endmodule

// ===== src/gffrc_checker.sv =====
module gffrc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    action,
  input logic                          done,
  input logic [gffrc_pkg::COUNT_W-1:0] region_count
);
  import gffrc_pkg::*;

  // a write item answers in the next cycle
  a_write_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_WRITE |=> done)
    else $error("write item without reply");

  // a read item answers after passing through the read state
  a_read_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_READ |-> ##2 done)
    else $error("read item without reply");

  // every reply leaves the block ready for the next item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("reply while busy");

  // the count only moves while a fill runs
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !start && !busy |=> $stable(region_count))
    else $error("count changed while idle");

endmodule

bind grid_flood_fill_region_counter gffrc_checker u_gffrc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .region_count (region_count)
);

// ===== bench/grid_flood_fill_region_counter_test.sv =====
module grid_flood_fill_region_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gffrc_pkg::*;

  localparam int ROWS = 16;
  localparam int COLS = 16;
  localparam int CELLS = ROWS * COLS;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 555;
  localparam int CALM_TAIL = 60;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [1:0] act;
    logic [3:0] r;
    logic [3:0] c;
    logic       op;
    bit         hold;
  } grid_item_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               mark;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = ACT_WRITE;
  logic [3:0] row = '0;
  logic [3:0] col = '0;
  logic open_flag = 1'b0;
  logic busy;
  logic done;
  logic [COUNT_W-1:0] region_count;
  logic mark;

  grid_item_t pending_items[$];
  grid_result_t expected_results[$];
  grid_item_t cur;

  bit grid_open[CELLS];
  bit grid_mark[CELLS];
  int walk_stack[CELLS];
  int walk_depth = 0;
  logic [COUNT_W-1:0] fill_count = '0;

  int errors = 0;
  int total_items = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_fills = 0;
  int n_reads = 0;
  int n_other = 0;
  int max_region = 0;
  int gap_left = 0;
  bit idle_on = 1'b1;

  grid_flood_fill_region_counter #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .row(row),
    .col(col),
    .open(open_flag),
    .done(done),
    .region_count(region_count),
    .mark(mark)
  );

  always #5 clk = ~clk;

  // grid model

  function automatic bit on_edge(int r, int c);
    return r == 0 || c == 0 || r == ROWS - 1 || c == COLS - 1;
  endfunction

  function automatic void enter_cell(int r, int c);
    int idx;
    idx = r * COLS + c;
    grid_mark[idx] = 1'b1;
    if (fill_count < COUNT_MAX) fill_count++;
    if (walk_depth < CELLS) begin
      walk_stack[walk_depth] = idx;
      walk_depth++;
    end
  endfunction

  function automatic void probe_cell(int r, int c);
    int idx;
    idx = r * COLS + c;
    if (grid_open[idx] && !grid_mark[idx]) begin
      if (!on_edge(r, c)) enter_cell(r, c);
    end else begin
      grid_mark[idx] = 1'b1;
    end
  endfunction

  function automatic void flood_from(int r, int c);
    int idx;
    int cr;
    int cc;
    for (int i = 0; i < CELLS; i++) grid_mark[i] = 1'b0;
    fill_count = '0;
    walk_depth = 0;
    if (r >= ROWS || c >= COLS || on_edge(r, c)) return;
    enter_cell(r, c);
    while (walk_depth > 0) begin
      walk_depth--;
      idx = walk_stack[walk_depth];
      cr = idx / COLS;
      cc = idx % COLS;
      probe_cell(cr + 1, cc);
      probe_cell(cr - 1, cc);
      probe_cell(cr, cc + 1);
      probe_cell(cr, cc - 1);
    end
  endfunction

  function automatic grid_result_t apply_item(grid_item_t it);
    grid_result_t res;
    int r;
    int c;
    bit in_grid;
    r = int'(it.r);
    c = int'(it.c);
    in_grid = r < ROWS && c < COLS;
    res.mark = 1'b0;
    case (it.act)
      ACT_WRITE: if (in_grid) grid_open[r * COLS + c] = it.op;
      ACT_FILL: flood_from(r, c);
      ACT_READ: if (in_grid) res.mark = grid_mark[r * COLS + c];
      default: ;
    endcase
    res.count = fill_count;
    return res;
  endfunction

  function automatic void add_item(logic [1:0] act, int r, int c, logic op, bit hold = 1'b0);
    grid_item_t it;
    it.act = act;
    it.r = r[3:0];
    it.c = c[3:0];
    it.op = op;
    it.hold = hold;
    pending_items.push_back(it);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // driver
  always @(posedge clk) begin : driver
    grid_result_t res;
    bit take;
    take = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (take) begin
        res = apply_item(cur);
        expected_results.push_back(res);
        n_accepted++;
        case (cur.act)
          ACT_WRITE: n_writes++;
          ACT_FILL: begin
            n_fills++;
            if (res.count > max_region) max_region = res.count;
          end
          ACT_READ: n_reads++;
          default: n_other++;
        endcase
        if (n_accepted % 40 == 0) idle_on = $urandom_range(0, 2) != 0;
        if (idle_on && n_accepted < total_items - CALM_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 9);
      end
      if (take || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold && expected_results.size() > 0)) begin
          cur = pending_items.pop_front();
          start <= 1'b1;
          action <= cur.act;
          row <= cur.r;
          col <= cur.c;
          open_flag <= cur.op;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    grid_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("result with nothing expected: count %0d mark %0d",
                             region_count, mark));
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (region_count !== want.count)
          note_error($sformatf("item %0d region_count expected %0d, got %0d",
                               n_checked, want.count, region_count));
        if (mark !== want.mark)
          note_error($sformatf("item %0d mark expected %0d, got %0d",
                               n_checked, want.mark, mark));
      end
    end
  end

  initial begin : stimulus
    int density;
    int roll;
    int r;
    int c;
    int last_r;
    int last_c;

    // closed start cell, its neighbors get marked
    add_item(ACT_READ, 0, 0, 1'b0);
    add_item(ACT_FILL, 7, 7, 1'b0);
    add_item(ACT_READ, 7, 7, 1'b0);
    add_item(ACT_READ, 6, 7, 1'b0);
    add_item(ACT_READ, 8, 8, 1'b0);
    // open border cell next to a small region
    add_item(ACT_WRITE, 1, 1, 1'b1);
    add_item(ACT_WRITE, 0, 1, 1'b1);
    add_item(ACT_WRITE, 1, 2, 1'b1);
    add_item(ACT_WRITE, 0, 0, 1'b1);
    add_item(ACT_WRITE, 15, 15, 1'b1);
    add_item(ACT_FILL, 1, 1, 1'b1);
    add_item(ACT_READ, 0, 1, 1'b0);
    add_item(ACT_READ, 1, 0, 1'b1);
    add_item(ACT_READ, 2, 2, 1'b0);
    // border starts and a start just inside the border
    add_item(ACT_FILL, 0, 0, 1'b0);
    add_item(ACT_READ, 1, 1, 1'b0);
    add_item(ACT_FILL, 15, 15, 1'b1);
    add_item(ACT_NONE, 15, 15, 1'b1);
    add_item(ACT_WRITE, 14, 14, 1'b1);
    add_item(ACT_FILL, 14, 14, 1'b0);
    add_item(ACT_READ, 15, 14, 1'b1);
    add_item(ACT_READ, 14, 15, 1'b0);
    add_item(ACT_WRITE, 1, 1, 1'b0);
    add_item(ACT_NONE, 0, 0, 1'b0);

    density = $urandom_range(15, 95);
    last_r = 7;
    last_c = 7;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) density = $urandom_range(15, 95);
      roll = $urandom_range(0, 99);
      r = $urandom_range(0, ROWS - 1);
      c = $urandom_range(0, COLS - 1);
      if (roll < 55) begin
        add_item(ACT_WRITE, r, c, $urandom_range(0, 99) < density, n == 0 || n == 300);
      end else if (roll < 68) begin
        if ($urandom_range(0, 9) != 0) begin
          r = $urandom_range(1, ROWS - 2);
          c = $urandom_range(1, COLS - 2);
        end
        last_r = r;
        last_c = c;
        add_item(ACT_FILL, r, c, $urandom_range(0, 1), n == 0 || n == 300);
      end else if (roll < 96) begin
        if ($urandom_range(0, 1) == 0) begin
          r = last_r + $urandom_range(0, 4) - 2;
          c = last_c + $urandom_range(0, 4) - 2;
          if (r < 0) r = 0;
          if (r > ROWS - 1) r = ROWS - 1;
          if (c < 0) c = 0;
          if (c > COLS - 1) c = COLS - 1;
        end
        add_item(ACT_READ, r, c, $urandom_range(0, 1), n == 0 || n == 300);
      end else begin
        add_item(ACT_NONE, r, c, $urandom_range(0, 1), n == 0 || n == 300);
      end
    end
    total_items = pending_items.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d writes, %0d fills, %0d reads and %0d unused-action items",
             n_writes, n_fills, n_reads, n_other);
    $display("%0d results checked, largest region %0d cells", n_checked, max_region);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== grid_flood_fill_region_counter.f =====
src/gffrc_pkg.sv
src/gffrc_cell_store.sv
src/gffrc_stack.sv
src/grid_flood_fill_region_counter.sv
src/gffrc_checker.sv
bench/grid_flood_fill_region_counter_test.sv
